@@ hw/rtl/magma_pkg.sv @@
// magma cipher package: s-boxes, key schedule and round function
`default_nettype none

package magma_pkg;

  localparam int unsigned HalfW     = 32;
  localparam int unsigned BlockW    = 64;
  localparam int unsigned NumKeys   = 8;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned NumRounds = 32;
  localparam int unsigned DescRnds  = 24;
  localparam int unsigned RotAmt    = 11;

  typedef logic [HalfW-1:0]   half_t;
  typedef logic [KeyIdxW-1:0] key_idx_t;
  typedef logic [3:0]         nib_t;

  typedef nib_t sbox_row_t [16];
  typedef sbox_row_t sbox_arr_t [8];

  localparam sbox_arr_t SBOX = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // key word for a round: 7 down to 0 three times, then 0 up to 7
  function automatic key_idx_t key_sel(input int unsigned rnd);
    int unsigned k;
    begin
      if (rnd < DescRnds) begin
        k = (NumKeys - 1) - (rnd % NumKeys);
      end else begin
        k = rnd - DescRnds;
      end
      key_sel = k[KeyIdxW-1:0];
    end
  endfunction

  // add key, substitute nibbles, rotate left
  function automatic half_t round_f(input half_t k, input half_t half);
    half_t sum;
    half_t sub;
    begin
      sum = k + half;
      for (int i = 0; i < 8; i++) begin
        sub[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
      end
      round_f = {sub[HalfW-RotAmt-1:0], sub[HalfW-1:HalfW-RotAmt]};
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/magma_block_encrypt_core.sv @@
// magma block encryption core: 32-stage round pipeline with key registers
//
//  channel  ports                                   direction  width
//  -------  --------------------------------------  ---------  -----
//  input    in_valid, in_stall, in_plain_block      in         64
//  result   out_valid, out_stall, out_cipher_block  out        64
//  config   cfg_wr_en, cfg_index, cfg_wdata         in         32
//
//  one transaction enters per cycle while the pipeline advances; each of the 32
//  rounds is one register stage, and a block passes stage 0 through stage 31
//  the last round stage is the output register; the whole pipeline holds
//  while that register is full and out_stall is high, and in_stall follows
//  synchronous active-low reset clears the stage valid bits and the key words
//  the user must write key words only while the pipeline is empty; the block does not enforce it
`default_nettype none

module magma_block_encrypt_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_plain_block,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_cipher_block,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int unsigned NStg = magma_pkg::NumRounds;
  localparam int unsigned Last = NStg - 1;

  // key words
  magma_pkg::half_t key_r [magma_pkg::NumKeys];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < magma_pkg::NumKeys; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  // stage s holds both halves after round s
  magma_pkg::half_t lo_r  [NStg];
  magma_pkg::half_t hi_r  [NStg];
  logic [NStg-1:0]  vld_r;

  // pipeline advance: everything moves unless the output register is blocked
  logic advance;
  assign advance  = !(vld_r[Last] && out_stall);
  assign in_stall = !advance;

  for (genvar s = 0; s < NStg; s++) begin : g_rnd
    magma_pkg::half_t lo_in, hi_in, lo_nxt, hi_nxt;
    logic             vld_nxt;

    // previous stage, or the incoming block for the first round
    always_comb begin
      if (s == 0) begin
        lo_in   = in_plain_block[31:0];
        hi_in   = in_plain_block[63:32];
        vld_nxt = in_valid;
      end else begin
        lo_in   = lo_r[(s == 0) ? 0 : s-1];
        hi_in   = hi_r[(s == 0) ? 0 : s-1];
        vld_nxt = vld_r[(s == 0) ? 0 : s-1];
      end
    end

    // even rounds update the high half from the low, odd rounds the reverse
    always_comb begin
      lo_nxt = lo_in;
      hi_nxt = hi_in;
      if (s % 2 == 0) begin
        hi_nxt = hi_in ^ magma_pkg::round_f(key_r[magma_pkg::key_sel(s)], lo_in);
      end else begin
        lo_nxt = lo_in ^ magma_pkg::round_f(key_r[magma_pkg::key_sel(s)], hi_in);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (advance) begin
        vld_r[s] <= vld_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        lo_r[s] <= lo_nxt;
        hi_r[s] <= hi_nxt;
      end
    end
  end

  // final low half goes on top
  assign out_valid        = vld_r[Last];
  assign out_cipher_block = {lo_r[Last], hi_r[Last]};

  // assertions

  // an accepted block occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  // an idle input cycle leaves a bubble in the first stage
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_valid && !in_stall) |=> !vld_r[0])
    else $error("pipeline invented a transaction");

  // a frozen pipeline keeps its first stage contents
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && vld_r[0]) |=> ($stable(lo_r[0]) && $stable(hi_r[0]) && vld_r[0]))
    else $error("first stage changed during a stall");

  // valid bits move one stage per advancing cycle
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && vld_r[Last-1]) |=> out_valid)
    else $error("transaction lost between last two stages");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench for the magma block encryption core: directed and random blocks checked in order
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [magma_pkg::BlockW-1:0] block_t;

  // key register map, one index per key word
  typedef enum logic [magma_pkg::KeyIdxW-1:0] {
    KEY_W0, KEY_W1, KEY_W2, KEY_W3, KEY_W4, KEY_W5, KEY_W6, KEY_W7
  } key_reg_e;

  // the eight substitution tables, entry [table][nibble]
  localparam logic [3:0] SUBST [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  localparam int unsigned PIPE_DEPTH = magma_pkg::NumRounds;  // one stage per round
  localparam int unsigned QUIET_LIMIT = 3000;      // cycles with no transaction
  localparam int unsigned HOLD_CYCLES = 300;       // long receiver hold-off
  localparam int unsigned PHASE_BLOCKS = 200;
  localparam int unsigned NUM_PHASES = 6;

  // scoreboard: own copy of the key, expected ciphertexts in arrival order
  class cipher_scoreboard;
    magma_pkg::half_t key_words [magma_pkg::NumKeys];
    block_t cipher_due [$];
    int unsigned mismatches;
    int unsigned compared;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      mismatches = 0;
      compared = 0;
    endfunction

    function void set_key(int unsigned idx, magma_pkg::half_t val);
      key_words[idx] = val;
    endfunction

    // add key word, substitute each nibble, rotate left
    function magma_pkg::half_t round_word(magma_pkg::half_t k, magma_pkg::half_t x);
      magma_pkg::half_t sum;
      magma_pkg::half_t sub;
      sum = k + x;
      for (int n = 0; n < 8; n++) sub[4*n +: 4] = SUBST[n][sum[4*n +: 4]];
      return (sub << magma_pkg::RotAmt) |
             (sub >> (magma_pkg::HalfW - magma_pkg::RotAmt));
    endfunction

    function block_t encrypt(block_t blk);
      magma_pkg::half_t lo;
      magma_pkg::half_t hi;
      int unsigned idx;
      lo = blk[magma_pkg::HalfW-1:0];
      hi = blk[magma_pkg::BlockW-1:magma_pkg::HalfW];
      // three passes with key words taken downward, two rounds per step
      for (int p = 0; p < magma_pkg::DescRnds / 2; p++) begin
        idx = (magma_pkg::NumKeys - 1) - 2 * (p % (magma_pkg::NumKeys / 2));
        hi ^= round_word(key_words[idx], lo);
        lo ^= round_word(key_words[idx-1], hi);
      end
      // last pass upward
      for (int p = 0; p < magma_pkg::NumKeys / 2; p++) begin
        idx = 2 * p;
        hi ^= round_word(key_words[idx], lo);
        lo ^= round_word(key_words[idx+1], hi);
      end
      return {lo, hi};
    endfunction

    function void note_block(block_t blk);
      cipher_due.push_back(encrypt(blk));
    endfunction

    function void check_block(block_t got);
      block_t want;
      if (cipher_due.size() == 0) begin
        $error("cipher_block %h arrived with no block outstanding", got);
        mismatches++;
      end else begin
        want = cipher_due.pop_front();
        compared++;
        if (got !== want) begin
          $error("cipher_block mismatch: expected %h, actual %h", want, got);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return cipher_due.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  logic [63:0]  in_plain_block;
  logic         out_valid;
  logic         out_stall;
  logic [63:0]  out_cipher_block;
  logic         cfg_wr_en;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  cipher_scoreboard sb = new();

  // idling percentages, changed by the main sequence per phase
  int unsigned send_gap_pct = 34;
  int unsigned recv_stall_pct = 58;
  bit          hold_req = 1'b0;
  int unsigned key_settings = 1;   // reset key counts as the first
  int unsigned quiet_cycles = 0;
  int unsigned full_stalls = 0;

  magma_block_encrypt_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_plain_block   (in_plain_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cipher_block (out_cipher_block),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: note accepted blocks, check accepted ciphertexts at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_block(in_plain_block);
      if (out_valid && !out_stall) sb.check_block(out_cipher_block);
      // in_stall with the sender waiting means the output register is full and held by the receiver
      if (in_valid && in_stall) full_stalls++;
    end
  end

  // watchdog: a long run of cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        // hold-off counted here while the sender keeps offering
        for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one block, called and returning at a falling edge
  task automatic send_block(input block_t blk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      in_plain_block <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_plain_block <= blk;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // all results back, then let the pipeline settle before touching the key
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  // write all eight key words on consecutive cycles, block idle
  task automatic load_key(input magma_pkg::half_t words [magma_pkg::NumKeys]);
    for (int i = 0; i < magma_pkg::NumKeys; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= key_reg_e'(i);
      cfg_wdata <= words[i];
      @(negedge clk);
      sb.set_key(i, words[i]);
    end
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    key_settings++;
  endtask

  function automatic magma_pkg::half_t rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic block_t rand_block();
    case ($urandom_range(11))
      0: return '0;
      1: return '1;
      2: return {32'h0, rand_word()};
      3: return {rand_word(), 32'h0};
      4: return block_t'(64'h1) << $urandom_range(magma_pkg::BlockW - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : main
    magma_pkg::half_t key_buf [magma_pkg::NumKeys];
    block_t           corner_blocks [7];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_plain_block = '0;
    cfg_wr_en = 1'b0;
    cfg_index = KEY_W0;
    cfg_wdata = '0;

    corner_blocks = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                      64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                      64'h0123_4567_89AB_CDEF};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: corner blocks under the all-zero reset key
    foreach (corner_blocks[i]) send_block(corner_blocks[i]);
    drain();

    // directed: corner blocks under the all-ones key, every add with a nonzero half wraps
    foreach (key_buf[i]) key_buf[i] = '1;
    load_key(key_buf);
    foreach (corner_blocks[i]) send_block(corner_blocks[i]);
    drain();

    // directed: the published example key and block, then the corners
    key_buf = '{32'hFCFD_FEFF, 32'hF8F9_FAFB, 32'hF4F5_F6F7, 32'hF0F1_F2F3,
                32'h3322_1100, 32'h7766_5544, 32'hBBAA_9988, 32'hFFEE_DDCC};
    load_key(key_buf);
    send_block(64'hFEDC_BA98_7654_3210);
    foreach (corner_blocks[i]) send_block(corner_blocks[i]);
    drain();

    // random phases: a fresh key each, idling profile by pairs of phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_gap_pct = 34;
          recv_stall_pct = 58;
        end
        1: begin
          send_gap_pct = 58;
          recv_stall_pct = 34;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      foreach (key_buf[i]) key_buf[i] = rand_word();
      load_key(key_buf);
      // with no idling the long hold-off fills the pipeline and stalls the input
      if (ph == NUM_PHASES - 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BLOCKS; n++) send_block(rand_block());
      drain();
    end

    $display("summary: %0d blocks compared under %0d key settings",
             sb.compared, key_settings);
    $display("summary: %0d cycles with the sender held by a full pipeline", full_stalls);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/magma_pkg.sv
hw/rtl/magma_block_encrypt_core.sv
tb/tb.sv
